>>> rtl/core/temporal_frame_averager_core_assert.svh
// Assertion macros used by the checker of the frame averager.
`ifndef TEMPORAL_FRAME_AVERAGER_CORE_ASSERT_SVH
`define TEMPORAL_FRAME_AVERAGER_CORE_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define TFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define TFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/tfa_pkg.sv
// Shared constants and types of the temporal frame averager.
package tfa_pkg;

   // Pixel channel and result field widths.
   localparam int PIX_W = 8;
   localparam int POS_W = 18;

   // Frame length register.
   localparam int FP_W = 19;
   localparam logic [FP_W-1:0] FP_RESET = 19'd230400;

   // Configuration port geometry and register map.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_PIXELS_ADDR = 2'd0;

   // Quotient steps: one clamp test plus one step per result bit.
   localparam int QUOT_STEPS = PIX_W + 1;
   localparam int STEP_W = $clog2(QUOT_STEPS);

   // Control handed from the sequencer to each divider.
   typedef struct packed {
      logic load;
      logic step;
   } tfa_div_ctrl_type;

endpackage

>>> rtl/core/tfa_channels.sv
// Valid/ready channel interfaces for pixels in and averages out.
interface tfa_pixel_if import tfa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface tfa_avg_if import tfa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] avg_red;
   logic [PIX_W-1:0] avg_green;
   logic [PIX_W-1:0] avg_blue;
   logic [POS_W-1:0] pixel_position;
   logic             frame_end;

   modport source (output valid, avg_red, avg_green, avg_blue, pixel_position, frame_end,
                   input ready);
   modport sink (input valid, avg_red, avg_green, avg_blue, pixel_position, frame_end,
                 output ready);
endinterface

>>> rtl/core/tfa_sum_mem.sv
// Single-port-write, single-port-read sum memory with registered read data.
module tfa_sum_mem #(
   parameter int DEPTH  = 262144,
   parameter int ADDR_W = 18,
   parameter int DATA_W = 96
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered, updated only when rd_en is high.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tfa_divider.sv
// Bit-serial restoring divider giving an 8-bit quotient clamped at its maximum.
module tfa_divider import tfa_pkg::*; #(
   parameter int SUM_W = 32,
   parameter int CNT_W = 24
) (
   input  logic             clock,
   input  tfa_div_ctrl_type ctrl,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic [PIX_W-1:0] quotient
);

   localparam int DIV_W = (SUM_W > CNT_W + PIX_W) ? SUM_W : CNT_W + PIX_W;

   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      den_ff, den_in;
   logic [QUOT_STEPS-1:0] q_ff, q_in;
   logic                  fits;

   // The first step tests the divisor shifted past the result width, which
   // flags a quotient that does not fit; each later step yields one bit.
   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      q_in   = q_ff;
      fits   = (DIV_W'(rem_ff) >= den_ff);
      if (ctrl.load) begin
         rem_in = dividend;
         den_in = DIV_W'(divisor) << PIX_W;
         q_in   = '0;
      end else if (ctrl.step) begin
         if (fits) begin
            rem_in = rem_ff - den_ff[SUM_W-1:0];
         end
         den_in = den_ff >> 1;
         q_in   = {q_ff[QUOT_STEPS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   // An overflowing quotient saturates to all ones.
   assign quotient = q_ff[QUOT_STEPS-1] ? '1 : q_ff[PIX_W-1:0];

endmodule

>>> rtl/core/temporal_frame_averager_core.sv
// Top level of the temporal frame averager: per-pixel running average over frames.
//
// Pixels enter on req_bus in raster order, one transaction per pixel. Each
// pixel gives exactly one transaction on rsp_bus with the truncated average
// of every channel over the frames seen so far, its raster position and a
// frame end flag. The frame length is set through the APB-style register at
// byte address 0 (frame_pixels), which the user must write only while the
// block is idle; the block itself does not enforce this. A pixel is worked
// on alone; its result shows on rsp_bus in the same cycle that the next
// pixel can be accepted. Its steps are the idle state that accepts it and
// issues the sum read, the read state that adds and writes the sums back,
// the 9-step quotient divider (one bit per cycle) and the done state that
// moves the quotients into the output register.
// Reset clears the position, sets the frame count to one and restores the
// frame length to 230400. The sums read as zero until written, tracked by a
// fill count, so there is no clearing pass and pixels are taken at once.
// If the receiver stalls, the finished result waits in the output register;
// one more pixel is taken and worked on, then the block holds until the
// waiting result is taken.
module temporal_frame_averager_core import tfa_pkg::*; #(
   parameter int MAX_PIXELS  = 262144,
   parameter int SUM_WIDTH   = 32,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   tfa_pixel_if.sink             req_bus,
   tfa_avg_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int FILL_W    = $clog2(MAX_PIXELS + 1);
   localparam int LEN_W     = (FILL_W > FP_W) ? FILL_W : FP_W;
   localparam int MEM_W     = 3 * SUM_WIDTH;
   localparam int SUM_EXT_W = SUM_WIDTH + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_STEPS - 1);

   // Control state.
   logic [1:0]             state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] frames_ff, frames_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [FP_W-1:0]        frame_pixels_ff, frame_pixels_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload of the pixel at work and of the waiting result.
   logic [PIX_W-1:0]  red_ff, red_in;
   logic [PIX_W-1:0]  green_ff, green_in;
   logic [PIX_W-1:0]  blue_ff, blue_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              hit_ff, hit_in;
   logic [POS_W-1:0]  item_pos_ff, item_pos_in;
   logic              item_end_ff, item_end_in;
   logic [PIX_W-1:0]  avg_red_ff, avg_red_in;
   logic [PIX_W-1:0]  avg_green_ff, avg_green_in;
   logic [PIX_W-1:0]  avg_blue_ff, avg_blue_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_end_ff, rsp_end_in;

   // Datapath signals.
   logic                   req_fire;
   logic                   csr_write;
   logic [ADDR_W-1:0]      addr_now;
   logic [LEN_W-1:0]       fp_ext;
   logic [LEN_W-1:0]       last_pos;
   logic                   is_last;
   logic                   frozen;
   logic [MEM_W-1:0]       mem_rd_data;
   logic [SUM_WIDTH-1:0]   old_red, old_green, old_blue;
   logic [SUM_WIDTH-1:0]   new_red, new_green, new_blue;
   logic                   mem_wr_en;
   tfa_div_ctrl_type       div_ctrl;
   logic [PIX_W-1:0]       q_red, q_green, q_blue;

   // Saturating add of one pixel value to a running sum.
   function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] sum,
                                                    input logic [PIX_W-1:0] pix);
      logic [SUM_EXT_W-1:0] total;
      total = {1'b0, sum} + SUM_EXT_W'(pix);
      return total[SUM_WIDTH] ? '1 : total[SUM_WIDTH-1:0];
   endfunction

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign csr_write = psel && penable && pwrite && (paddr == CSR_FRAME_PIXELS_ADDR);
   assign addr_now  = ADDR_W'(pos_ff);

   // Last position of the effective frame: a zero length counts as one and
   // a length past the memory depth is held at the depth.
   always_comb begin
      fp_ext = LEN_W'(frame_pixels_ff);
      priority if (fp_ext == '0) begin
         last_pos = '0;
      end else if (fp_ext > LEN_W'(MAX_PIXELS)) begin
         last_pos = LEN_W'(MAX_PIXELS - 1);
      end else begin
         last_pos = fp_ext - LEN_W'(1);
      end
      is_last = (LEN_W'(pos_ff) >= last_pos);
   end

   // Once the frame count is at its maximum the sums stay as they are.
   assign frozen = &frames_ff;

   // Entries at or above the fill count were never written and read as zero.
   assign old_red   = hit_ff ? mem_rd_data[3*SUM_WIDTH-1:2*SUM_WIDTH] : '0;
   assign old_green = hit_ff ? mem_rd_data[2*SUM_WIDTH-1:SUM_WIDTH] : '0;
   assign old_blue  = hit_ff ? mem_rd_data[SUM_WIDTH-1:0] : '0;

   assign new_red   = frozen ? old_red : sat_add(old_red, red_ff);
   assign new_green = frozen ? old_green : sat_add(old_green, green_ff);
   assign new_blue  = frozen ? old_blue : sat_add(old_blue, blue_ff);

   assign mem_wr_en = (state_ff == ST_READ) && !frozen;
   assign div_ctrl  = {(state_ff == ST_READ), (state_ff == ST_DIV)};

   // Sequencer: read the sums, write them back, divide, hand over the result.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      frames_in    = frames_ff;
      fill_in      = fill_ff;
      step_in      = step_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      item_pos_in  = item_pos_ff;
      item_end_in  = item_end_ff;
      avg_red_in   = avg_red_ff;
      avg_green_in = avg_green_ff;
      avg_blue_in  = avg_blue_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               red_in   = req_bus.red;
               green_in = req_bus.green;
               blue_in  = req_bus.blue;
               addr_in  = addr_now;
               hit_in   = (FILL_W'(addr_now) < fill_ff);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            item_pos_in = pos_ff;
            item_end_in = is_last;
            pos_in      = is_last ? '0 : pos_ff + POS_W'(1);
            if (is_last && !frozen) begin
               frames_in = frames_ff + COUNT_WIDTH'(1);
            end
            if (mem_wr_en && (FILL_W'(addr_ff) >= fill_ff)) begin
               fill_in = FILL_W'(addr_ff) + FILL_W'(1);
            end
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               avg_red_in   = q_red;
               avg_green_in = q_green;
               avg_blue_in  = q_blue;
               rsp_pos_in   = item_pos_ff;
               rsp_end_in   = item_end_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Frame length register.
   assign frame_pixels_in = csr_write ? pwdata[FP_W-1:0] : frame_pixels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pos_ff          <= '0;
         frames_ff       <= COUNT_WIDTH'(1);
         fill_ff         <= '0;
         frame_pixels_ff <= FP_RESET;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         frames_ff       <= frames_in;
         fill_ff         <= fill_in;
         frame_pixels_ff <= frame_pixels_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      addr_ff      <= addr_in;
      hit_ff       <= hit_in;
      item_pos_ff  <= item_pos_in;
      item_end_ff  <= item_end_in;
      avg_red_ff   <= avg_red_in;
      avg_green_ff <= avg_green_in;
      avg_blue_ff  <= avg_blue_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // Running sums of all three channels, one entry per pixel position.
   tfa_sum_mem #(
      .DEPTH  (MAX_PIXELS),
      .ADDR_W (ADDR_W),
      .DATA_W (MEM_W)
   ) u_sum_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (addr_now),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (addr_ff),
      .wr_data ({new_red, new_green, new_blue})
   );

   // One divider per channel, all stepped together.
   tfa_divider #(.SUM_W(SUM_WIDTH), .CNT_W(COUNT_WIDTH)) u_div_red (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (new_red),
      .divisor  (frames_ff),
      .quotient (q_red)
   );

   tfa_divider #(.SUM_W(SUM_WIDTH), .CNT_W(COUNT_WIDTH)) u_div_green (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (new_green),
      .divisor  (frames_ff),
      .quotient (q_green)
   );

   tfa_divider #(.SUM_W(SUM_WIDTH), .CNT_W(COUNT_WIDTH)) u_div_blue (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (new_blue),
      .divisor  (frames_ff),
      .quotient (q_blue)
   );

   // Channel outputs.
   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.avg_red        = avg_red_ff;
   assign rsp_bus.avg_green      = avg_green_ff;
   assign rsp_bus.avg_blue       = avg_blue_ff;
   assign rsp_bus.pixel_position = rsp_pos_ff;
   assign rsp_bus.frame_end      = rsp_end_ff;

   // Register read-back.
   assign prdata = (paddr == CSR_FRAME_PIXELS_ADDR) ? CSR_DATA_W'(frame_pixels_ff) : '0;
   assign pready = 1'b1;

endmodule

>>> rtl/core/tfa_checker.sv
// Port-level checker for the temporal frame averager and its bind statement.
`include "temporal_frame_averager_core_assert.svh"

module tfa_checker import tfa_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [POS_W-1:0] rsp_pixel_position,
   input logic             rsp_frame_end
);

   // No result is offered in the cycle after reset.
   `TFA_ASSERT_ALWAYS(a_no_result_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // A pixel is worked on alone, so input closes right after a transaction.
   `TFA_ASSERT(a_one_pixel_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "input open while a pixel is at work")

   // Handing over a fresh result frees the input side in the same cycle.
   `TFA_ASSERT(a_result_frees_input, clock, reset, $rose(rsp_valid) |-> req_ready, "input closed when a result appears")

   // A stalled result keeps its position and frame end flag.
   `TFA_ASSERT(a_stalled_result_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_position) && $stable(rsp_frame_end), "stalled result changed")

endmodule

bind temporal_frame_averager_core tfa_checker u_tfa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_pixel_position (rsp_bus.pixel_position),
   .rsp_frame_end      (rsp_bus.frame_end)
);

>>> test/tfa_average_checker.sv
// Checker for the frame averager: predicts each average and compares result transactions.
`timescale 1ns / 100ps

module tfa_average_checker import tfa_pkg::*; #(
   parameter int MAX_PIXELS  = 262144,
   parameter int SUM_WIDTH   = 32,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   tfa_pixel_if                  pix,
   tfa_avg_if                    avg,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [POS_W-1:0] position;
      logic             frame_end;
   } avg_result_type;

   typedef struct packed {
      logic [SUM_WIDTH-1:0] red;
      logic [SUM_WIDTH-1:0] green;
      logic [SUM_WIDTH-1:0] blue;
   } channel_sums_type;

   // Shadow copy of the block state; sums never written read as zero.
   logic [FP_W-1:0]        frame_len;
   logic [POS_W-1:0]       position;
   logic [COUNT_WIDTH-1:0] frames;
   channel_sums_type       pixel_sums [int unsigned];
   avg_result_type         expected_averages [$];
   int                     errors;

   // A running sum stops at its largest value instead of wrapping.
   function automatic logic [SUM_WIDTH-1:0] add_clamped(input logic [SUM_WIDTH-1:0] sum,
                                                        input logic [PIX_W-1:0] value);
      logic [SUM_WIDTH:0] wide;
      wide = {1'b0, sum} + value;
      return wide[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : wide[SUM_WIDTH-1:0];
   endfunction

   // Truncated quotient of a sum by the frame count, clamped to the channel range.
   function automatic logic [PIX_W-1:0] channel_average(input logic [SUM_WIDTH-1:0] sum,
                                                        input logic [COUNT_WIDTH-1:0] count);
      logic [SUM_WIDTH-1:0] quotient;
      quotient = (count == '0) ? sum : sum / count;
      return (quotient > 255) ? 8'hFF : quotient[PIX_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      int unsigned      span;
      int unsigned      addr;
      logic             last;
      logic             frozen;
      channel_sums_type cur;
      avg_result_type   want;
      avg_result_type   got;
      if (reset) begin
         frame_len = FP_RESET;
         position  = '0;
         frames    = COUNT_WIDTH'(1);
         pixel_sums.delete();
         expected_averages.delete();
         errors    = 0;
      end else begin
         // Track writes of the frame length register.
         if (psel && penable && pwrite && pready && paddr == CSR_FRAME_PIXELS_ADDR) begin
            frame_len = pwdata[FP_W-1:0];
         end

         // Predict the result of every accepted pixel transaction.
         if (pix.valid && pix.ready) begin
            span = (frame_len == '0) ? 1 : int'(frame_len);
            if (span > MAX_PIXELS) begin
               span = MAX_PIXELS;
            end
            last   = (position >= span - 1);
            addr   = position % MAX_PIXELS;
            frozen = (frames == {COUNT_WIDTH{1'b1}});
            cur    = pixel_sums.exists(addr) ? pixel_sums[addr] : '0;
            if (!frozen) begin
               cur.red   = add_clamped(cur.red, pix.red);
               cur.green = add_clamped(cur.green, pix.green);
               cur.blue  = add_clamped(cur.blue, pix.blue);
               pixel_sums[addr] = cur;
            end
            want.red       = channel_average(cur.red, frames);
            want.green     = channel_average(cur.green, frames);
            want.blue      = channel_average(cur.blue, frames);
            want.position  = position;
            want.frame_end = last;
            expected_averages.push_back(want);
            if (last) begin
               position = '0;
               if (!frozen) begin
                  frames = frames + 1'b1;
               end
            end else begin
               position = position + 1'b1;
            end
         end

         // Compare every accepted result transaction with the oldest prediction.
         if (avg.valid && avg.ready) begin
            got.red       = avg.avg_red;
            got.green     = avg.avg_green;
            got.blue      = avg.avg_blue;
            got.position  = avg.pixel_position;
            got.frame_end = avg.frame_end;
            if (expected_averages.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected result: r=%0d g=%0d b=%0d pos=%0d end=%0b",
                           got.red, got.green, got.blue, got.position, got.frame_end);
               end
            end else begin
               want = expected_averages.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch: expected r=%0d g=%0d b=%0d pos=%0d end=%0b",
                              want.red, want.green, want.blue, want.position, want.frame_end);
                     $display("          actual   r=%0d g=%0d b=%0d pos=%0d end=%0b",
                              got.red, got.green, got.blue, got.position, got.frame_end);
                  end
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_averages.size();
   end

endmodule

>>> test/tb_temporal_frame_averager_core.sv
// Testbench top of the frame averager: clock, reset, pixel stimulus, register writes, verdict.
`timescale 1ns / 100ps

module tb_temporal_frame_averager_core;
   import tfa_pkg::*;

   localparam int MAX_PIXELS    = 262144;
   localparam int SUM_WIDTH     = 32;
   localparam int COUNT_WIDTH   = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 4000;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending;
   logic                  idle_on;
   int                    hold_requests;
   int                    quiet_cycles;

   tfa_pixel_if pix_bus ();
   tfa_avg_if   avg_bus ();

   temporal_frame_averager_core #(
      .MAX_PIXELS (MAX_PIXELS),
      .SUM_WIDTH  (SUM_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(pix_bus),
      .rsp_bus(avg_bus),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   tfa_average_checker #(
      .MAX_PIXELS (MAX_PIXELS),
      .SUM_WIDTH  (SUM_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) average_check (
      .clock     (clock),
      .reset     (reset),
      .pix       (pix_bus),
      .avg       (avg_bus),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .pready    (pready),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .fail_count(fail_count),
      .pending   (pending)
   );

   // 20 ns clock.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stop the run when no transaction has moved for too long.
   always @(posedge clock) begin
      if (reset || (pix_bus.valid && pix_bus.ready) || (avg_bus.valid && avg_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_temporal_frame_averager_core NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result receiver: random stall bursts and one long hold-off on request.
   initial begin : receiver
      int stall_left;
      int holds_served;
      stall_left   = 0;
      holds_served = 0;
      avg_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (hold_requests > holds_served) begin
            holds_served++;
            avg_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            avg_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            avg_bus.ready <= 1'b0;
         end else begin
            avg_bus.ready <= 1'b1;
         end
      end
   end

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_frame_pixels(input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_FRAME_PIXELS_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Stop offering pixels and wait until every predicted result has come out.
   task automatic settle_block();
      pix_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one pixel, maybe after a short gap, and wait for its transaction.
   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         pix_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pix_bus.valid <= 1'b1;
      pix_bus.red   <= r;
      pix_bus.green <= g;
      pix_bus.blue  <= b;
      do @(posedge clock); while (!pix_bus.ready);
   endtask

   // Channel values lean toward the extremes now and then.
   function automatic logic [PIX_W-1:0] pick_channel();
      unique case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin : stimulus
      logic [PIX_W-1:0]      dir_red   [8];
      logic [PIX_W-1:0]      dir_green [8];
      logic [PIX_W-1:0]      dir_blue  [8];
      logic [CSR_DATA_W-1:0] phase_word [10];
      int                    phase_items [10];
      int                    i;
      int                    p;

      dir_red     = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hAA, 8'h55, 8'h01};
      dir_green   = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h80};
      dir_blue    = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFE};
      // Frame lengths per phase; one above the memory size and one with high junk bits.
      phase_word  = '{32'd1, 32'd3, 32'd7, 32'd16, 32'd2, 32'h0007_FFFF, 32'd262144,
                      32'hFFF8_0005, 32'd33, 32'd4};
      phase_items = '{210, 210, 210, 210, 210, 100, 100, 210, 210, 210};

      idle_on       = 1'b1;
      hold_requests = 0;
      reset         <= 1'b1;
      pix_bus.valid <= 1'b0;
      pix_bus.red   <= '0;
      pix_bus.green <= '0;
      pix_bus.blue  <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Channel extremes with the reset frame length.
      for (i = 0; i < 8; i++) begin
         send_pixel(dir_red[i], dir_green[i], dir_blue[i]);
      end

      // Shrink the frame below the current position, then run a few short frames.
      settle_block();
      write_frame_pixels(32'd4);
      for (i = 0; i < 12; i++) begin
         send_pixel(dir_red[(i + 3) % 8], dir_green[i % 8], dir_blue[(i + 5) % 8]);
      end

      // A frame length of zero acts as one pixel per frame.
      settle_block();
      write_frame_pixels(32'd0);
      for (i = 0; i < 4; i++) begin
         send_pixel(dir_red[i], dir_green[i + 4], dir_blue[i]);
      end

      // Random phases over several frame lengths; the last one runs without idling.
      for (p = 0; p < 10; p++) begin
         settle_block();
         write_frame_pixels(phase_word[p]);
         if (p == 9) begin
            idle_on = 1'b0;
         end
         for (i = 0; i < phase_items[p]; i++) begin
            if (p == 1 && i == 5) begin
               hold_requests++;
            end
            if (p == 3 && i == 100) begin
               settle_block();
            end
            send_pixel(pick_channel(), pick_channel(), pick_channel());
         end
      end

      settle_block();
      if (fail_count == 0 && pending == 0) begin
         $display("tb_temporal_frame_averager_core OK");
      end else begin
         $display("tb_temporal_frame_averager_core NOT OK");
      end
      $finish;
   end

endmodule
